/* src/ptd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptd_pkg
// Shared types for the trial-division prime factorizer: sequencer states and
// the status word that the divider returns to the sequencer.
// ----------------------------------------------------------------------------
package ptd_pkg;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV_WAIT,
		ST_DECIDE
	} ptd_state_t;

	typedef struct packed {
		logic done;
		logic rem_zero;
	} ptd_div_status_t;

endpackage
`default_nettype wire

/* src/ptd_divider.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptd_divider
// Restoring divider, one quotient bit per cycle. A start loads the operands,
// and done pulses as the last bit lands, quotient and remainder registered.
// ----------------------------------------------------------------------------
module ptd_divider
	import ptd_pkg::*;
#(
	parameter int WIDTH = 20
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [WIDTH-1:0] dividend,
	input  wire logic [WIDTH-1:0] divisor,
	output logic [WIDTH-1:0]      quotient,
	output ptd_div_status_t       status
);

	localparam int CntW = $clog2(WIDTH);
	localparam logic [CntW-1:0] LastCnt = CntW'(WIDTH - 1);

	logic            run_q;
	logic            done_q;
	logic [CntW-1:0] cnt_q;
	logic [WIDTH-1:0] quo_q;
	logic [WIDTH-1:0] rem_q;
	logic [WIDTH-1:0] div_q;

	logic [WIDTH:0]   trial;
	logic             fits;

	// The partial remainder shifts in the next dividend bit; the quotient
	// register holds the unused dividend bits above the finished quotient bits.
	always_comb begin
		trial = {rem_q, quo_q[WIDTH-1]} - {1'b0, div_q};
		fits  = ~trial[WIDTH];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LastCnt) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (run_q) begin
			quo_q <= {quo_q[WIDTH-2:0], fits};
			rem_q <= fits ? trial[WIDTH-1:0] : {rem_q[WIDTH-2:0], quo_q[WIDTH-1]};
		end
	end

	assign quotient        = quo_q;
	assign status.done     = done_q;
	assign status.rem_zero = (rem_q == '0);

endmodule
`default_nettype wire

/* src/prime_factorizer_trial_division.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prime_factorizer_trial_division
// Factors an unsigned integer into primes in ascending order by trial division.
// ----------------------------------------------------------------------------
// Usage:
//   Drive value and raise start; the word is taken at a clock edge where busy
//   is low. busy stays high while the number is being factored.
//   Each prime factor appears on factor for exactly one cycle with valid high;
//   last is set on the final factor of the word. Values below four come back
//   unchanged as a single factor. The receiver cannot stall the output.
// Timing:
//   One shared restoring divider does all the work, one quotient bit per
//   cycle. A trial divisor costs a bound check, a division and a decision;
//   each factor divided out costs another division and decision, and the
//   divisor square d*d is kept by an incremental add. busy drops in the
//   cycle the last factor is shown, so a new word may follow.
// Reset:
//   arst_n returns the sequencer to idle; no result is pending afterwards.
// ----------------------------------------------------------------------------
module prime_factorizer_trial_division
	import ptd_pkg::*;
#(
	parameter int VALUE_WIDTH = 20
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	input  wire logic [VALUE_WIDTH-1:0] value,
	output logic                        busy,
	output logic                        valid,
	output logic [VALUE_WIDTH-1:0]      factor,
	output logic                        last
);

	localparam logic [VALUE_WIDTH-1:0] FirstDiv = VALUE_WIDTH'(2);
	localparam logic [VALUE_WIDTH:0]   FirstSq  = (VALUE_WIDTH + 1)'(4);

	ptd_state_t state_q, state_d;

	logic [VALUE_WIDTH-1:0] rem_q;
	logic [VALUE_WIDTH-1:0] d_q;
	logic [VALUE_WIDTH:0]   sq_q;
	logic                   valid_q;
	logic [VALUE_WIDTH-1:0] factor_q;
	logic                   last_q;

	logic [VALUE_WIDTH-1:0] quotient;
	ptd_div_status_t        div_status;
	logic [VALUE_WIDTH-1:0] div_dividend;

	logic accept;
	logic in_bound;
	logic hit;
	logic div_start;
	logic emit_div;
	logic emit_last;
	logic step_div;

	assign accept   = start && (state_q == ST_IDLE);
	assign in_bound = (sq_q <= {1'b0, rem_q});
	assign hit      = div_status.rem_zero && (rem_q != d_q);

	// After a factor is divided out, the next division runs on the fresh
	// quotient with the same divisor.
	assign div_dividend = emit_div ? quotient : rem_q;

	ptd_divider #(
		.WIDTH(VALUE_WIDTH)
	) u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (d_q),
		.quotient (quotient),
		.status   (div_status)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) state_d = ST_CHECK;
			end
			ST_CHECK: begin
				state_d = in_bound ? ST_DIV_WAIT : ST_IDLE;
			end
			ST_DIV_WAIT: begin
				if (div_status.done) state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				state_d = hit ? ST_DIV_WAIT : ST_CHECK;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Control outputs of the sequencer.
	always_comb begin
		div_start = 1'b0;
		emit_div  = 1'b0;
		emit_last = 1'b0;
		step_div  = 1'b0;
		unique case (state_q)
			ST_IDLE: ;
			ST_CHECK: begin
				div_start = in_bound;
				emit_last = ~in_bound;
			end
			ST_DIV_WAIT: ;
			ST_DECIDE: begin
				div_start = hit;
				emit_div  = hit;
				step_div  = ~hit;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			valid_q <= emit_div || emit_last;
		end
	end

	// Datapath: remaining value, trial divisor and its square.
	always_ff @(posedge clk) begin
		if (accept) begin
			rem_q <= value;
			d_q   <= FirstDiv;
			sq_q  <= FirstSq;
		end else if (emit_div) begin
			rem_q <= quotient;
		end else if (step_div) begin
			// (d + 1)^2 = d^2 + 2d + 1
			d_q  <= d_q + 1'b1;
			sq_q <= sq_q + {d_q, 1'b1};
		end
		if (emit_div) begin
			factor_q <= d_q;
			last_q   <= 1'b0;
		end else if (emit_last) begin
			factor_q <= rem_q;
			last_q   <= 1'b1;
		end
	end

	assign busy   = (state_q != ST_IDLE);
	assign valid  = valid_q;
	assign factor = factor_q;
	assign last   = last_q;

endmodule
`default_nettype wire

/* dv/prime_factorizer_trial_division_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prime_factorizer_trial_division_tb
// Self-checking bench for the trial-division prime factorizer. Words are
// sent in bursts with random gaps, and every value is factored again inside
// the bench. Each factor that comes back is compared, together with its last
// flag, against the oldest factor that is still outstanding.
// ----------------------------------------------------------------------------
module prime_factorizer_trial_division_tb;

	localparam int VALUE_WIDTH = 20;
	localparam longint unsigned VALUE_MASK = (64'd1 << VALUE_WIDTH) - 64'd1;
	localparam int RANDOM_WORDS = 77;

	typedef logic [VALUE_WIDTH-1:0] value_t;

	typedef struct {
		value_t factor;
		logic   last;
	} factor_t;

	class factor_scoreboard;
		factor_t expected_factors[$];
		int      mismatches;
		int      words_noted;
		int      factors_checked;

		function new();
			mismatches      = 0;
			words_noted     = 0;
			factors_checked = 0;
		endfunction

		// Splits an accepted word into its primes and queues them in order.
		function void note_word(input value_t word);
			longint unsigned rem;
			longint unsigned d;
			factor_t         item;
			rem = longint'(word) & VALUE_MASK;
			d   = 2;
			while (d * d <= rem) begin
				while ((rem % d) == 0 && rem != d) begin
					item.factor = value_t'(d);
					item.last   = 1'b0;
					expected_factors = {expected_factors, item};
					rem = rem / d;
				end
				d++;
			end
			item.factor = value_t'(rem);
			item.last   = 1'b1;
			expected_factors = {expected_factors, item};
			words_noted++;
		endfunction

		function void check_factor(input value_t factor, input logic last);
			factor_t want;
			factors_checked++;
			if (expected_factors.size() == 0) begin
				$error("factor %0d (last %0b) arrived with nothing outstanding", factor, last);
				mismatches++;
			end else begin
				want = expected_factors.pop_front();
				if (factor !== want.factor) begin
					$error("factor: expected %0d, actual %0d", want.factor, factor);
					mismatches++;
				end
				if (last !== want.last) begin
					$error("last: expected %0b, actual %0b", want.last, last);
					mismatches++;
				end
			end
		endfunction

		function int pending();
			return expected_factors.size();
		endfunction
	endclass

	logic   clk;
	logic   arst_n;
	logic   start;
	value_t value;
	logic   busy;
	logic   valid;
	value_t factor;
	logic   last;

	factor_scoreboard sb = new();

	prime_factorizer_trial_division #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.value (value),
		.busy  (busy),
		.valid (valid),
		.factor(factor),
		.last  (last)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// The timeout allows several times the slowest full run.
	initial begin
		#144_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && valid) begin
			sb.check_factor(factor, last);
		end
	end

	// Start stays high from one word to the next inside a burst.
	task automatic drive_word(input value_t word);
		@(negedge clk);
		start <= 1'b1;
		value <= word;
		@(posedge clk);
		while (busy) @(posedge clk);
		sb.note_word(word);
	endtask

	task automatic idle_gap(input int cycles);
		if (cycles > 0) begin
			@(negedge clk);
			start <= 1'b0;
			value <= value_t'($urandom);
			repeat (cycles - 1) @(negedge clk);
		end
	endtask

	function automatic value_t pick_word();
		int              kind;
		int              primes[15];
		longint unsigned prod;
		longint unsigned q;
		primes = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47};
		kind = $urandom_range(0, 99);
		if (kind < 45) begin
			// Products of small primes stay fast and still reach the top bits.
			prod = 1;
			repeat ($urandom_range(1, 20)) begin
				q = primes[$urandom_range(0, 14)];
				if (prod * q <= VALUE_MASK) prod = prod * q;
			end
			return value_t'(prod);
		end else if (kind < 75) begin
			return value_t'($urandom_range(0, 4095));
		end else if (kind < 87) begin
			return value_t'($urandom_range(0, 255));
		end else begin
			return value_t'($urandom);
		end
	endfunction

	initial begin
		value_t directed[$];
		int     sent;
		int     burst;
		arst_n = 1'b0;
		start  = 1'b0;
		value  = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		idle_gap(3);

		// Values below four, small primes and composites, a prime square,
		// powers of two, full-width primes and alternating bit patterns.
		directed = {20'd0, 20'd1, 20'd2, 20'd3, 20'd4, 20'd5, 20'd6, 20'd7, 20'd8,
			20'd9, 20'd12, 20'd25, 20'd97,
			20'd524288, 20'd786432, 20'd1048575, 20'd1048573, 20'd1048574,
			20'd999983, 20'd1018081, 20'hAAAAA, 20'h55555, 20'd65536};
		foreach (directed[i]) begin
			drive_word(directed[i]);
			if ($urandom_range(0, 2) == 0) idle_gap($urandom_range(1, 40));
		end

		sent = 0;
		while (sent < RANDOM_WORDS) begin
			burst = $urandom_range(1, 8);
			repeat (burst) begin
				drive_word(pick_word());
				sent++;
			end
			case ($urandom_range(0, 3))
				0: ;
				1: idle_gap($urandom_range(1, 8));
				2: idle_gap($urandom_range(9, 200));
				default: idle_gap($urandom_range(200, 3000));
			endcase
		end
		idle_gap(1);

		while (sb.pending() != 0) @(posedge clk);
		repeat (64) @(posedge clk);

		$display("Sent %0d words and checked %0d factors.", sb.words_noted, sb.factors_checked);
		$display("Values below four, prime powers and 20-bit primes were among them.");
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

/* sim.f */
src/ptd_pkg.sv
src/ptd_divider.sv
src/prime_factorizer_trial_division.sv
dv/prime_factorizer_trial_division_tb.sv
